// ----- rtl/signed_angle_between_vectors_macros.svh -----
// Assertion macros shared by the signed vector angle block.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef SIGNED_ANGLE_BETWEEN_VECTORS_MACROS_SVH
`define SIGNED_ANGLE_BETWEEN_VECTORS_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SABV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SABV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sabv_pkg.sv -----
// Shared types, constants and the CORDIC angle table of the vector angle block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sabv_pkg;

   // Field widths of the streaming channels.
   localparam int FIELD_W        = 16;
   localparam int ANGLE_W        = 16;
   localparam int MAX_COORD_BITS = 32;

   // Defaults of the top-level parameters.
   localparam int COORD_BITS_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // CORDIC datapath formats.
   localparam int ATAN_TABLE_LEN = 24;
   localparam int NORM_BITS      = 30;
   localparam int XY_W           = 34;
   localparam int Z_W            = 28;
   localparam int PHI_W          = 15;
   localparam int QUARTER_FINE   = 94371840;
   localparam int ROUND_BIAS     = 4096;
   localparam int FRAC_DROP      = 13;

   // Exact angles in 1/128 degree.
   localparam int HALF_TURN    = 23040;
   localparam int QUARTER_TURN = 11520;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   // Item kinds decided by the front part.
   localparam logic KIND_FIXED  = 1'b0;
   localparam logic KIND_CORDIC = 1'b1;

   // Control word that travels with each item from front to back.
   typedef struct packed {
      logic               kind;
      logic               dneg;
      logic               cneg;
      logic               degen;
      logic [ANGLE_W-1:0] angle;
   } ctl_type;

   // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
   function automatic logic signed [Z_W-1:0] atan_fine(input int idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         0:       val = 28'sd47185920;
         1:       val = 28'sd27855475;
         2:       val = 28'sd14718068;
         3:       val = 28'sd7471121;
         4:       val = 28'sd3750058;
         5:       val = 28'sd1876857;
         6:       val = 28'sd938658;
         7:       val = 28'sd469357;
         8:       val = 28'sd234682;
         9:       val = 28'sd117342;
         10:      val = 28'sd58671;
         11:      val = 28'sd29335;
         12:      val = 28'sd14668;
         13:      val = 28'sd7334;
         14:      val = 28'sd3667;
         15:      val = 28'sd1833;
         16:      val = 28'sd917;
         17:      val = 28'sd458;
         18:      val = 28'sd229;
         19:      val = 28'sd115;
         20:      val = 28'sd57;
         21:      val = 28'sd29;
         22:      val = 28'sd14;
         23:      val = 28'sd7;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/sabv_front.sv -----
// Front part: accepts vector pairs, forms exact dot and cross products,
// and classifies each item. Depends on sabv_pkg.
`timescale 1ns / 1ps

module sabv_front
   import sabv_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // first_x, first_y, second_x, second_y, 16 bits each from the lowest bit up
   input  logic [4*FIELD_W-1:0]    req_tdata,
   output logic                    push_valid,
   input  logic                    push_full,
   output ctl_type                 push_ctl,
   output logic [2*COORD_BITS-1:0] push_dmag,
   output logic [2*COORD_BITS-1:0] push_cmag
);

   localparam int CW = COORD_BITS;
   localparam int PW = 2 * CW;
   localparam int SW = PW + 1;

   logic                         fen;
   logic [MAX_COORD_BITS-1:0]    ext_ax, ext_ay, ext_bx, ext_by;
   logic signed [CW-1:0]         ax, ay, bx, by;
   logic                         v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0]         p_axbx_ff, p_ayby_ff, p_axby_ff, p_aybx_ff;
   logic signed [SW-1:0]         dot_ff, cross_ff;
   logic signed [SW-1:0]         dot_abs, cross_abs;
   logic                         dneg, cneg, dzero, czero;
   ctl_type                      ctl_in, ctl_ff;
   logic [PW-1:0]                dmag_ff, cmag_ff;

   // The whole front advances unless its last stage holds an item the queue cannot take.
   assign fen        = !v3_ff || !push_full;
   assign req_tready = fen;

   // Each coordinate is the low COORD_BITS bits of its zero-extended field.
   assign ext_ax = {{(MAX_COORD_BITS-FIELD_W){1'b0}}, req_tdata[0*FIELD_W +: FIELD_W]};
   assign ext_ay = {{(MAX_COORD_BITS-FIELD_W){1'b0}}, req_tdata[1*FIELD_W +: FIELD_W]};
   assign ext_bx = {{(MAX_COORD_BITS-FIELD_W){1'b0}}, req_tdata[2*FIELD_W +: FIELD_W]};
   assign ext_by = {{(MAX_COORD_BITS-FIELD_W){1'b0}}, req_tdata[3*FIELD_W +: FIELD_W]};
   assign ax = ext_ax[CW-1:0];
   assign ay = ext_ay[CW-1:0];
   assign bx = ext_bx[CW-1:0];
   assign by = ext_by[CW-1:0];

   // Valid bits of the three front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (fen) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage one: the four exact products.
   always_ff @(posedge clock) begin
      if (fen) begin
         p_axbx_ff <= ax * bx;
         p_ayby_ff <= ay * by;
         p_axby_ff <= ax * by;
         p_aybx_ff <= ay * bx;
      end
   end

   // Stage two: dot and cross products, one bit wider than a product.
   always_ff @(posedge clock) begin
      if (fen) begin
         dot_ff   <= SW'(p_axbx_ff) + SW'(p_ayby_ff);
         cross_ff <= SW'(p_axby_ff) - SW'(p_aybx_ff);
      end
   end

   // Sign and magnitude of both products.
   assign dneg      = dot_ff[SW-1];
   assign cneg      = cross_ff[SW-1];
   assign dzero     = (dot_ff == '0);
   assign czero     = (cross_ff == '0);
   assign dot_abs   = dneg ? -dot_ff : dot_ff;
   assign cross_abs = cneg ? -cross_ff : cross_ff;

   // Axis-aligned and degenerate cases get their angle here; the rest go to CORDIC.
   always_comb begin
      ctl_in.kind  = KIND_FIXED;
      ctl_in.dneg  = dneg;
      ctl_in.cneg  = cneg;
      ctl_in.degen = 1'b0;
      ctl_in.angle = '0;
      if (czero) begin
         if (dzero) begin
            ctl_in.degen = 1'b1;
         end else if (dneg) begin
            ctl_in.angle = ANGLE_W'(HALF_TURN);
         end
      end else if (dzero) begin
         ctl_in.angle = cneg ? ANGLE_W'(-QUARTER_TURN) : ANGLE_W'(QUARTER_TURN);
      end else begin
         ctl_in.kind = KIND_CORDIC;
      end
   end

   // Stage three: classified item waiting for the queue.
   always_ff @(posedge clock) begin
      if (fen) begin
         ctl_ff  <= ctl_in;
         dmag_ff <= dot_abs[PW-1:0];
         cmag_ff <= cross_abs[PW-1:0];
      end
   end

   assign push_valid = v3_ff && !push_full;
   assign push_ctl   = ctl_ff;
   assign push_dmag  = dmag_ff;
   assign push_cmag  = cmag_ff;

endmodule

// ----- rtl/sabv_queue.sv -----
// Short first-in first-out queue that decouples the front and back parts.
// Depends on sabv_pkg for the default depth and on the macros header for its assertions.
`timescale 1ns / 1ps
`include "signed_angle_between_vectors_macros.svh"

module sabv_queue
   import sabv_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage is written only; its contents need no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SABV_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "queue overfilled")
   `SABV_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count missed a push")
   `SABV_ASSERT_NEXT(a_count_hold, clock, reset, push && pop, count_ff == $past(count_ff), "queue count moved on push with pop")

endmodule

// ----- rtl/sabv_back.sv -----
// Back part: normalizes the product magnitudes, runs the CORDIC vectoring
// pipeline and folds the angle into the full circle. Depends on sabv_pkg.
`timescale 1ns / 1ps
`include "signed_angle_between_vectors_macros.svh"

module sabv_back
   import sabv_pkg::*;
#(
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_empty,
   output logic                    pop,
   input  ctl_type                 pop_ctl,
   input  logic [2*COORD_BITS-1:0] pop_dmag,
   input  logic [2*COORD_BITS-1:0] pop_cmag,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // angle, 16 bits signed
   output logic [ANGLE_W-1:0]      rsp_tdata,
   // degenerate, 1 bit
   output logic                    rsp_tuser
);

   localparam int PW  = 2 * COORD_BITS;
   localparam int NW  = (PW > NORM_BITS) ? PW : NORM_BITS;
   localparam int SH  = $clog2(NW);
   localparam int NS  = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS : ATAN_TABLE_LEN;
   localparam int T   = SH + NS + 2;

   localparam logic signed [Z_W-1:0] Q_FINE     = Z_W'(QUARTER_FINE);
   localparam logic signed [ANGLE_W:0] ANG_MAX  = (ANGLE_W + 1)'(HALF_TURN);
   localparam logic signed [ANGLE_W:0] ANG_MIN  = (ANGLE_W + 1)'(-HALF_TURN);

   logic                     en;
   logic                     vld_ff [T];
   ctl_type                  ctl_ff [T];
   logic [NW-1:0]            na_ff [SH+1];
   logic [NW-1:0]            nb_ff [SH+1];
   logic signed [XY_W-1:0]   cx_ff [NS+1];
   logic signed [XY_W-1:0]   cy_ff [NS+1];
   logic signed [Z_W-1:0]    cz_ff [NS+1];
   logic signed [Z_W-1:0]    z_clamp;
   logic [Z_W-1:0]           z_round;
   logic [PHI_W-1:0]         theta, phi;
   logic [ANGLE_W-1:0]       angle_cordic;
   logic                     rsp_tvalid_ff;
   logic [ANGLE_W-1:0]       rsp_tdata_ff;
   logic                     rsp_tuser_ff;
   ctl_type                  ctl_last;
   logic signed [ANGLE_W:0]  rsp_angle_ext;

   // The back pipeline moves whenever the output register is free or being drained.
   assign en  = !rsp_tvalid_ff || rsp_tready;
   assign pop = en && !pop_empty;

   // Valid bits along the whole back pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < T; t++) begin
            vld_ff[t] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= !pop_empty;
         for (int t = 1; t < T; t++) begin
            vld_ff[t] <= vld_ff[t-1];
         end
      end
   end

   // Control words ride alongside the data.
   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff[0] <= pop_ctl;
         for (int t = 1; t < T; t++) begin
            ctl_ff[t] <= ctl_ff[t-1];
         end
         na_ff[0] <= NW'(pop_dmag);
         nb_ff[0] <= NW'(pop_cmag);
      end
   end

   // Normalizer: each stage shifts both magnitudes left by a power of two
   // while the top bits of their OR are clear, leaving the larger one's MSB on top.
   for (genvar k = 0; k < SH; k++) begin : g_norm
      localparam int S = 2 ** (SH - 1 - k);
      logic [NW-1:0] orv;
      assign orv = na_ff[k] | nb_ff[k];
      always_ff @(posedge clock) begin
         if (en) begin
            if (orv[NW-1 -: S] == '0) begin
               na_ff[k+1] <= na_ff[k] << S;
               nb_ff[k+1] <= nb_ff[k] << S;
            end else begin
               na_ff[k+1] <= na_ff[k];
               nb_ff[k+1] <= nb_ff[k];
            end
         end
      end
   end

   // The top bits give the magnitudes scaled so the larger lies in [2^29, 2^30).
   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0] <= XY_W'(na_ff[SH][NW-1 -: NORM_BITS]);
         cy_ff[0] <= XY_W'(nb_ff[SH][NW-1 -: NORM_BITS]);
         cz_ff[0] <= '0;
      end
   end

   // CORDIC vectoring, one rotation per stage, driving y toward zero.
   for (genvar i = 0; i < NS; i++) begin : g_cordic
      localparam logic signed [Z_W-1:0] ANG = atan_fine(i);
      logic signed [XY_W-1:0] xs, ys;
      assign xs = cx_ff[i] >>> i;
      assign ys = cy_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (!cy_ff[i][XY_W-1]) begin
               cx_ff[i+1] <= cx_ff[i] + ys;
               cy_ff[i+1] <= cy_ff[i] - xs;
               cz_ff[i+1] <= cz_ff[i] + ANG;
            end else begin
               cx_ff[i+1] <= cx_ff[i] - ys;
               cy_ff[i+1] <= cy_ff[i] + xs;
               cz_ff[i+1] <= cz_ff[i] - ANG;
            end
         end
      end
   end

   // Clamp to the first quadrant, round to 1/128 degree, fold and sign.
   assign ctl_last = ctl_ff[T-1];
   always_comb begin
      if (cz_ff[NS] < 0) begin
         z_clamp = '0;
      end else if (cz_ff[NS] > Q_FINE) begin
         z_clamp = Q_FINE;
      end else begin
         z_clamp = cz_ff[NS];
      end
      z_round      = z_clamp + Z_W'(ROUND_BIAS);
      theta        = PHI_W'(z_round >> FRAC_DROP);
      phi          = ctl_last.dneg ? PHI_W'(HALF_TURN) - theta : theta;
      angle_cordic = ctl_last.cneg ? -ANGLE_W'(phi) : ANGLE_W'(phi);
   end

   // Output register: holds a finished item while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= vld_ff[T-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= (ctl_last.kind == KIND_CORDIC) ? angle_cordic : ctl_last.angle;
         rsp_tuser_ff <= ctl_last.degen;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Sign-extended copy of the result angle for the range check.
   assign rsp_angle_ext = $signed({rsp_tdata_ff[ANGLE_W-1], rsp_tdata_ff});

   `SABV_ASSERT_NOW(a_degen_zero, clock, reset, rsp_tvalid_ff && rsp_tuser_ff,
      rsp_tdata_ff == '0, "degenerate item with nonzero angle")
   `SABV_ASSERT_NOW(a_angle_range, clock, reset, rsp_tvalid_ff,
      (rsp_angle_ext <= ANG_MAX) && (rsp_angle_ext >= ANG_MIN), "angle outside half turn")
   `SABV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid_ff && !rsp_tready,
      rsp_tvalid_ff && $stable(rsp_tdata_ff) && $stable(rsp_tuser_ff),
      "result item changed while stalled")

endmodule

// ----- rtl/signed_angle_between_vectors.sv -----
// Signed angle between two 2-D vectors.
// Input channel (req_): one item is a pair of vectors (first_x, first_y,
// second_x, second_y), 16-bit signed each, packed into req_tdata.
// Result channel (rsp_): one item per input item, in order; rsp_tdata holds
// the angle from the first vector to the second in 1/128 degree (-180..+180),
// rsp_tuser is raised when both dot and cross products are zero.
// Throughput: one item per cycle, sustained while the receiver does not stall.
// On its way to rsp_tvalid an item passes the three front stages, the queue,
// the back input register, the normalizer shift stages, the CORDIC load
// register, one CORDIC rotation stage per step and the output register.
// When the receiver stalls, the back pipeline holds, the queue fills, and then
// req_tready drops; no item is lost or repeated. Reset empties every stage and
// the queue; the block is ready as soon as reset goes low.
// Depends on sabv_pkg, sabv_front, sabv_queue and sabv_back.
`timescale 1ns / 1ps

module signed_angle_between_vectors
   import sabv_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // first_x, first_y, second_x, second_y, 16 bits each from the lowest bit up
   input  logic [4*FIELD_W-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // angle, 16 bits signed
   output logic [ANGLE_W-1:0]   rsp_tdata,
   // degenerate, 1 bit
   output logic                 rsp_tuser
);

   localparam int PW = 2 * COORD_BITS;
   localparam int CTL_W = $bits(ctl_type);
   localparam int QW = CTL_W + 2 * PW;

   logic            push_valid, q_full, q_pop, q_empty;
   ctl_type         push_ctl, pop_ctl;
   logic [PW-1:0]   push_dmag, push_cmag, pop_dmag, pop_cmag;
   logic [QW-1:0]   q_in, q_out;

   // Front part: products and classification.
   sabv_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_full  (q_full),
      .push_ctl   (push_ctl),
      .push_dmag  (push_dmag),
      .push_cmag  (push_cmag)
   );

   // Queue between the two parts.
   assign q_in = {push_ctl, push_dmag, push_cmag};

   sabv_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign pop_ctl  = q_out[QW-1 -: CTL_W];
   assign pop_dmag = q_out[2*PW-1 -: PW];
   assign pop_cmag = q_out[PW-1:0];

   // Back part: normalizer, CORDIC and output register.
   sabv_back #(
      .COORD_BITS   (COORD_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_empty  (q_empty),
      .pop        (q_pop),
      .pop_ctl    (pop_ctl),
      .pop_dmag   (pop_dmag),
      .pop_cmag   (pop_cmag),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- tb/tb_signed_angle_between_vectors.sv -----
// Self-checking testbench of the signed vector angle block: directed corner cases and
// random vector pairs, with random idling on both stream sides and a built-in predictor.
// Depends on sabv_pkg and the signed_angle_between_vectors top level.
`timescale 1ns / 1ps

module tb_signed_angle_between_vectors
   import sabv_pkg::*;
();

   localparam int TB_CORDIC_STEPS = CORDIC_STEPS_DEF;
   localparam int TB_COORD_BITS   = COORD_BITS_DEF;
   // Idle tail at the end, after every pending result has been checked.
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 100000;
   localparam longint QUARTER_FINE_DEG = 64'd90 << 20;

   typedef logic signed [FIELD_W-1:0] coord_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic                      degenerate;
   } angle_result_type;

   typedef struct packed {
      coord_type        ax;
      coord_type        ay;
      coord_type        bx;
      coord_type        by;
      angle_result_type result;
   } pending_angle_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [4*FIELD_W-1:0] req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [ANGLE_W-1:0]   rsp_tdata;
   logic                 rsp_tuser;

   pending_angle_type pending_angles[$];
   bit             sender_idles   = 1'b1;
   bit             receiver_idles = 1'b1;
   int             mismatch_count  = 0;
   int             items_sent      = 0;
   int             results_checked = 0;
   int             degenerate_seen = 0;
   int             half_turns_seen = 0;
   int             cycle_count     = 0;

   always #5 clock = ~clock;

   signed_angle_between_vectors #(
      .CORDIC_STEPS(TB_CORDIC_STEPS),
      .COORD_BITS  (TB_COORD_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // CORDIC step angles atan(2^-i) in units of 2^-20 degree.
   function automatic longint atan_step(input int idx);
      case (idx)
         0:       return 47185920;
         1:       return 27855475;
         2:       return 14718068;
         3:       return 7471121;
         4:       return 3750058;
         5:       return 1876857;
         6:       return 938658;
         7:       return 469357;
         8:       return 234682;
         9:       return 117342;
         10:      return 58671;
         11:      return 29335;
         12:      return 14668;
         13:      return 7334;
         14:      return 3667;
         15:      return 1833;
         16:      return 917;
         17:      return 458;
         18:      return 229;
         19:      return 115;
         20:      return 57;
         21:      return 29;
         22:      return 14;
         23:      return 7;
         default: return 0;
      endcase
   endfunction

   // Angle of (a, b) with a, b >= 0 in 1/128 degree, 0..11520.
   function automatic longint quadrant_angle(input longint a, input longint b);
      longint m, x, y, z, xs, ys;
      m = (a > b) ? a : b;
      // Normalize so that the larger magnitude lies in [2^29, 2^30).
      while (m >= (longint'(1) << 30)) begin
         m = m >> 1;
         a = a >> 1;
         b = b >> 1;
      end
      while (m < (longint'(1) << 29)) begin
         m = m << 1;
         a = a << 1;
         b = b << 1;
      end
      x = a;
      y = b;
      z = 0;
      // Vectoring: drive y toward zero, accumulating the rotation in z.
      for (int i = 0; i < TB_CORDIC_STEPS && i < ATAN_TABLE_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_step(i);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_step(i);
         end
      end
      if (z < 0) z = 0;
      if (z > QUARTER_FINE_DEG) z = QUARTER_FINE_DEG;
      return (z + 4096) >> 13;
   endfunction

   // Signed angle from the first vector to the second, with the degenerate flag.
   function automatic angle_result_type predict_angle(input coord_type ax, input coord_type ay,
                                                      input coord_type bx, input coord_type by);
      longint dot, crs, dmag, cmag, phi, angle;
      angle_result_type r;
      dot  = longint'(ax) * longint'(bx) + longint'(ay) * longint'(by);
      crs  = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
      dmag = (dot < 0) ? -dot : dot;
      cmag = (crs < 0) ? -crs : crs;
      r.degenerate = 1'b0;
      if (cmag == 0) begin
         // Collinear: exactly 0 or a half turn, or no direction at all.
         r.degenerate = (dmag == 0);
         angle = (dot < 0) ? HALF_TURN : 0;
      end else begin
         if (dmag == 0)
            phi = QUARTER_TURN;
         else if (dot < 0)
            phi = HALF_TURN - quadrant_angle(dmag, cmag);
         else
            phi = quadrant_angle(dmag, cmag);
         angle = (crs < 0) ? -phi : phi;
      end
      r.angle = ANGLE_W'(angle);
      return r;
   endfunction

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Sends one vector pair, after a random gap when sender idling is on, and records its expected angle.
   task automatic send_pair(input coord_type ax, input coord_type ay,
                            input coord_type bx, input coord_type by);
      int                gap;
      pending_angle_type entry;
      gap = sender_idles ? int'($urandom_range(0, 7)) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {by, bx, ay, ax};
      do @(posedge clock); while (!req_tready);
      entry.ax     = ax;
      entry.ay     = ay;
      entry.bx     = bx;
      entry.by     = by;
      entry.result = predict_angle(ax, ay, bx, by);
      pending_angles.push_back(entry);
      items_sent++;
   endtask

   // Sends one vector pair given as plain integers.
   task automatic send_ints(input int ax, input int ay, input int bx, input int by);
      send_pair(coord_type'(ax), coord_type'(ay), coord_type'(bx), coord_type'(by));
   endtask

   // Draws a signed value in -span..span.
   function automatic int spread(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Zero vectors, collinear and perpendicular pairs, field extremes, near half turns.
   task automatic test_directed;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      send_ints(0, 0, 0, 0);
      send_ints(0, 0, 123, -45);
      send_ints(-32768, 32767, 0, 0);
      send_ints(1, 0, 5, 0);
      send_ints(3, 4, -6, -8);
      send_ints(1, 0, 0, 1);
      send_ints(0, 1, 1, 0);
      send_ints(1, 0, 1, 1);
      send_ints(1, 1, 1, 0);
      send_ints(1, 0, -1, 1);
      send_ints(1, 0, -1, -1);
      send_ints(-32768, -32768, -32768, -32768);
      send_ints(32767, 32767, -32768, -32768);
      send_ints(-32768, 0, 0, -32768);
      send_ints(-32768, 32767, -32768, -32768);
      send_ints(32767, -32768, -32768, 32767);
      send_ints(32767, 0, -32767, -1);
      send_ints(32767, 0, -32767, 1);
      send_ints(32767, 0, 32767, 1);
      send_ints(32767, 0, 32767, -1);
      send_ints(-1, -1, -1, -1);
   endtask

   // Full-range coordinates, receiver stalling against a busy sender.
   task automatic test_random_full(input int count);
      sender_idles   = 1'b0;
      receiver_idles = 1'b1;
      repeat (count)
         send_pair(coord_type'($urandom()), coord_type'($urandom()),
                   coord_type'($urandom()), coord_type'($urandom()));
   endtask

   // Tiny coordinates, so zero products and exact angles come often.
   task automatic test_random_small(input int count);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (count)
         send_ints(spread(3), spread(3), spread(3), spread(3));
   endtask

   // Second vector a multiple of the first, slightly disturbed: angles near 0 and 180.
   task automatic test_near_collinear(input int count);
      int ax, ay, k;
      sender_idles   = 1'b1;
      receiver_idles = 1'b0;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) begin
            ax = int'(coord_type'($urandom()));
            ay = int'(coord_type'($urandom()));
            k  = ($urandom_range(0, 1) == 0) ? 1 : -1;
         end else begin
            ax = spread(8000);
            ay = spread(8000);
            k  = spread(4);
         end
         send_ints(ax, ay, k * ax + spread(2), k * ay + spread(2));
      end
   endtask

   // Second vector a multiple of the first turned a quarter, slightly disturbed.
   task automatic test_near_perpendicular(input int count);
      int ax, ay, k;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (count) begin
         ax = spread(8000);
         ay = spread(8000);
         k  = spread(4);
         send_ints(ax, ay, -k * ay + spread(2), k * ax + spread(2));
      end
   endtask

   // Back-to-back items with no idling on either side.
   task automatic test_burst(input int count);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      repeat (count)
         send_pair(coord_type'($urandom()), coord_type'($urandom()),
                   coord_type'($urandom()), coord_type'($urandom()));
   endtask

   // Result side: a random stall before each item is taken while receiver idling is on.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_idles ? int'($urandom_range(0, 7)) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      pending_angle_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_angles.size() == 0) begin
            report_mismatch($sformatf("result angle=%0d flag=%0b with nothing pending",
                                      $signed(rsp_tdata), rsp_tuser));
         end else begin
            want = pending_angles.pop_front();
            results_checked++;
            if (want.result.degenerate) degenerate_seen++;
            if (want.result.angle == HALF_TURN || want.result.angle == -HALF_TURN)
               half_turns_seen++;
            if (rsp_tdata !== want.result.angle)
               report_mismatch($sformatf("(%0d,%0d)->(%0d,%0d) angle %0d, expected %0d",
                                         want.ax, want.ay, want.bx, want.by,
                                         $signed(rsp_tdata), want.result.angle));
            if (rsp_tuser !== want.result.degenerate)
               report_mismatch($sformatf("(%0d,%0d)->(%0d,%0d) degenerate %b, expected %b",
                                         want.ax, want.ay, want.bx, want.by,
                                         rsp_tuser, want.result.degenerate));
         end
      end
   end

   // Guards against a hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Reset, the tests in turn, drain and verdict.
   initial begin
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      reset      <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_full(250);
      test_random_small(150);
      test_near_collinear(150);
      test_near_perpendicular(100);
      test_burst(100);
      req_tvalid <= 1'b0;

      while (pending_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d of %0d vector pairs, %0d mismatches.",
               results_checked, items_sent, mismatch_count);
      $display("Among them %0d degenerate pairs and %0d half-turn angles.",
               degenerate_seen, half_turns_seen);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
